/* design/circular_deque_assert.svh */
// Assertion macros shared by the circular_deque RTL.
// Expects clk and rst in the scope of each use.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// Checked outside reset.
`define CDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define CDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/cdq_pkg.sv */
// Package for the circular deque: action codes, field widths and the
// controller-to-datapath command struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD_BACK  = 3'd0,
    ACT_ADD_FRONT = 3'd1,
    ACT_DEL_FRONT = 3'd2,
    ACT_DEL_BACK  = 3'd3,
    ACT_NONE      = 3'd4
  } action_t;

  typedef struct packed {
    logic accept;  // take the input beat, update pointers, write, read
    logic load;    // move read results into the output register
  } cmd_t;

endpackage

`default_nettype wire

/* design/cdq_ram.sv */
// Generic simple dual-port RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

/* design/cdq_ctrl.sv */
// Controller for the circular deque: sequences accept, read and output load.
// Depends on cdq_pkg and circular_deque_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "circular_deque_assert.svh"

module cdq_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire logic         out_stall,
  output cdq_pkg::cmd_t     cmd
);

  typedef enum logic {
    S_IDLE,
    S_WAIT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state == S_WAIT);
  assign cmd.accept = (state == S_IDLE) && in_valid;
  assign cmd.load   = (state == S_WAIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
          if (in_valid) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CDQ_ASSERT(a_accept_then_wait, cmd.accept |=> (in_stall && !cmd.accept), "accept not followed by wait")
  `CDQ_ASSERT(a_load_sets_valid, cmd.load |=> out_valid, "load did not raise out_valid")

endmodule

`default_nettype wire

/* design/cdq_dp.sv */
// Datapath for the circular deque: head/fill pointers, slot RAM, bypass and
// output register. Depends on cdq_pkg, cdq_ram and circular_deque_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "circular_deque_assert.svh"

module cdq_dp #(
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire cdq_pkg::cmd_t                        cmd,
  input  wire logic        [cdq_pkg::ACTION_W-1:0]  action,
  input  wire logic signed [cdq_pkg::VALUE_W-1:0]   value,
  output logic signed      [cdq_pkg::VALUE_W-1:0]   front_value,
  output logic signed      [cdq_pkg::VALUE_W-1:0]   back_value,
  output logic             [cdq_pkg::COUNT_W-1:0]   count,
  output logic                                      is_empty,
  output logic                                      rejected
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int VW = cdq_pkg::VALUE_W;
  localparam int NW = cdq_pkg::COUNT_W;

  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_F = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    return (s >= DEPTH_S) ? AW'(s - DEPTH_S) : AW'(s);
  endfunction

  logic [AW-1:0] head, head_next;
  logic [CW-1:0] fill, fill_next;
  logic          wr_en, blocked;
  logic [AW-1:0] wr_addr, front_addr, back_addr;
  logic [VW-1:0] rd_front, rd_back;

  logic          front_hit, back_hit, empty_q, rejected_q;
  logic [VW-1:0] byp_data;
  logic [CW-1:0] fill_q;
  logic [CW+NW-1:0] fill_ext;

  always_comb begin
    head_next = head;
    fill_next = fill;
    wr_en     = 1'b0;
    wr_addr   = head;
    blocked   = 1'b0;
    case (cdq_pkg::action_t'(action))
      cdq_pkg::ACT_ADD_BACK: begin
        if (fill == DEPTH_F) begin
          blocked = 1'b1;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = wrap(SW'(head) + SW'(fill));
          fill_next = fill + CW'(1);
        end
      end
      cdq_pkg::ACT_ADD_FRONT: begin
        if (fill == DEPTH_F) begin
          blocked = 1'b1;
        end else begin
          head_next = (head == '0) ? LAST_A : head - AW'(1);
          wr_en     = 1'b1;
          wr_addr   = head_next;
          fill_next = fill + CW'(1);
        end
      end
      cdq_pkg::ACT_DEL_FRONT: begin
        if (fill != '0) begin
          head_next = wrap(SW'(head) + SW'(1));
          fill_next = fill - CW'(1);
        end
      end
      cdq_pkg::ACT_DEL_BACK: begin
        if (fill != '0) begin
          fill_next = fill - CW'(1);
        end
      end
      default: begin
      end
    endcase
    front_addr = head_next;
    back_addr  = (fill_next != '0) ? wrap(SW'(head_next) + SW'(fill_next) - SW'(1)) : head_next;
  end

  cdq_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (cmd.accept && wr_en),
    .waddr   (wr_addr),
    .wdata   (VW'(value)),
    .re      (cmd.accept),
    .raddr_a (front_addr),
    .raddr_b (back_addr),
    .rdata_a (rd_front),
    .rdata_b (rd_back)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (cmd.accept) begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  // write lands on the same edge as the read, so forward it
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      front_hit  <= wr_en && (wr_addr == front_addr);
      back_hit   <= wr_en && (wr_addr == back_addr);
      byp_data   <= VW'(value);
      empty_q    <= (fill_next == '0);
      rejected_q <= blocked;
      fill_q     <= fill_next;
    end
  end

  assign fill_ext = {{NW{1'b0}}, fill_q};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      front_value <= empty_q ? '0 : (front_hit ? byp_data : rd_front);
      back_value  <= empty_q ? '0 : (back_hit ? byp_data : rd_back);
      count       <= fill_ext[NW-1:0];
      is_empty    <= empty_q;
      rejected    <= rejected_q;
    end
  end

  `CDQ_ASSERT_ALWAYS(a_fill_bound, (rst || fill <= DEPTH_F), "fill above depth")
  `CDQ_ASSERT(a_full_add_holds, (cmd.accept && blocked) |=> (fill == $past(fill) && head == $past(head) && rejected_q), "dropped add changed state")
  `CDQ_ASSERT(a_empty_tracks, cmd.accept |=> (empty_q == (fill == '0)), "empty flag out of step with fill")

endmodule

`default_nettype wire

/* design/circular_deque.sv */
// Top level of the circular deque: controller plus datapath.
// Depends on cdq_pkg, cdq_ctrl, cdq_dp (and through it cdq_ram).
//
//   channel | handshake             | beat fields
//   --------+-----------------------+---------------------------------------------
//   in      | in_valid / in_stall   | action, value
//   out     | out_valid / out_stall | front_value, back_value, count, is_empty,
//           |                       | rejected
//
// Input beats are taken one at a time: the accept edge updates the pointers,
// writes the slot RAM and launches the front and back reads; the load, once the
// output is free, fills the output register from the registered read data.
// Reset clears pointers and control only; the slot RAM needs no clearing.
// A stalled output holds the next item in the wait state; in_stall is high there.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque #(
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic        [cdq_pkg::ACTION_W-1:0]  action,
  input  wire logic signed [cdq_pkg::VALUE_W-1:0]   value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed      [cdq_pkg::VALUE_W-1:0]   front_value,
  output logic signed      [cdq_pkg::VALUE_W-1:0]   back_value,
  output logic             [cdq_pkg::COUNT_W-1:0]   count,
  output logic                                      is_empty,
  output logic                                      rejected
);

  cdq_pkg::cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .action      (action),
    .value       (value),
    .front_value (front_value),
    .back_value  (back_value),
    .count       (count),
    .is_empty    (is_empty),
    .rejected    (rejected)
  );

endmodule

`default_nettype wire
